// ===== rtl/core/text_console_char_writer_macros.svh =====
// Assertion shorthands used by the console controller RTL.
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tccw_pkg.sv =====
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  ATTR_WHITE = 8'h0F;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a command
    logic exec;       // run the captured command
    logic take_read;  // latch read data into the result
    logic clr_step;   // blank one cell of the full sweep
    logic copy_step;  // read one cell of the scroll copy
    logic fill_step;  // blank one cell of the bottom row
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic       need_scroll;
    logic       last_cell;
    logic       copy_last;
  } stat_t;

endpackage

// ===== rtl/core/tccw_datapath.sv =====
module tccw_datapath #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic           clk,
  input  logic           rst,
  input  tccw_pkg::ctl_t ctl,
  output tccw_pkg::stat_t stat,
  input  logic [1:0]     mode,
  input  logic [7:0]     char_code,
  input  logic [10:0]    cell_index,
  output logic [10:0]    cursor_position,
  output logic [15:0]    cell_value
);
  import tccw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CX_W   = $clog2(COLUMNS + 8);
  localparam int RX_W   = $clog2(ROWS + 1);
  localparam int POS_W  = (ADDR_W > 11) ? ADDR_W : 11;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic [1:0]        mode_q;
  logic [7:0]        char_q;
  logic [10:0]       idx_q;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] sweep;
  logic              copy_vld;
  logic [ADDR_W-1:0] copy_dst;

  logic [ADDR_W-1:0] cur_addr;
  logic [POS_W-1:0]  pos_ext;
  logic [POS_W-1:0]  idx_ext;
  logic              in_range;
  logic              printable;
  logic [CX_W-1:0]   col_x;
  logic [CX_W-1:0]   tab_sum;
  logic [CX_W-1:0]   col_n;
  logic [RX_W-1:0]   row_n;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W-1:0]  row_fin;
  logic              need_scroll;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign cur_addr  = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign pos_ext   = POS_W'(cur_addr);
  assign cursor_position = pos_ext[10:0];
  assign idx_ext   = POS_W'(idx_q);
  assign in_range  = 32'(idx_q) < CELLS;
  assign printable = !char_q[7] && (char_q >= CH_SPACE);
  assign col_x     = CX_W'(col);
  assign tab_sum   = col_x + CX_W'(8);

  // cursor motion for one put byte, then wrap and scroll check
  always_comb begin
    col_n = col_x;
    row_n = RX_W'(row);
    priority if (char_q == CH_BS) begin
      if (col_x != '0) col_n = col_x - CX_W'(1);
    end else if (char_q == CH_TAB) begin
      col_n = {tab_sum[CX_W-1:3], 3'b000};
    end else if (char_q == CH_CR) begin
      col_n = '0;
    end else if (char_q == CH_LF) begin
      col_n = '0;
      row_n = row_n + RX_W'(1);
    end else if (printable) begin
      col_n = col_x + CX_W'(1);
    end else begin
      // control and high bytes leave the cursor alone
      col_n = col_x;
    end
    if (col_n >= CX_W'(COLUMNS)) begin
      col_n = '0;
      row_n = row_n + RX_W'(1);
    end
    need_scroll = row_n >= RX_W'(ROWS);
    col_fin = col_n[COL_W-1:0];
    row_fin = need_scroll ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
  end

  assign stat.mode        = mode_q;
  assign stat.need_scroll = need_scroll;
  assign stat.last_cell   = sweep == ADDR_W'(CELLS - 1);
  assign stat.copy_last   = sweep == ADDR_W'(CELLS - COLUMNS - 1);

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = BLANK_CELL;
    priority if (copy_vld) begin
      wr_en   = 1'b1;
      wr_addr = copy_dst;
      wr_data = rdata;
    end else if (ctl.clr_step || ctl.fill_step) begin
      wr_en   = 1'b1;
    end else if (ctl.exec && mode_q == MODE_PUT && printable) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = {ATTR_WHITE, char_q};
    end else begin
      wr_en   = 1'b0;
    end
  end

  assign rd_en   = ctl.copy_step || (ctl.exec && mode_q == MODE_READ);
  assign rd_addr = ctl.copy_step ? sweep + ADDR_W'(COLUMNS) : idx_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mode_q <= mode;
      char_q <= char_code;
      idx_q  <= cell_index;
    end
    copy_dst <= sweep;
    if (ctl.exec) cell_value <= '0;
    else if (ctl.take_read) cell_value <= in_range ? rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      sweep    <= '0;
      copy_vld <= 1'b0;
    end else begin
      copy_vld <= ctl.copy_step;
      if (ctl.exec) sweep <= '0;
      else if (ctl.clr_step || ctl.copy_step || ctl.fill_step) sweep <= sweep + ADDR_W'(1);
      if (ctl.clr_step) begin
        col <= '0;
        row <= '0;
      end else if (ctl.exec && mode_q == MODE_PUT) begin
        col <= col_fin;
        row <= row_fin;
      end
    end
  end

endmodule

// ===== rtl/core/tccw_ctrl.sv =====
`include "text_console_char_writer_macros.svh"

module tccw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output tccw_pkg::ctl_t  ctl,
  input  tccw_pkg::stat_t stat
);
  import tccw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_COPY, ST_DRAIN, ST_FILL
  } state_t;

  state_t state;
  logic   clr_report;

  assign busy = state != ST_IDLE;

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_CLEAR: ctl.clr_step  = 1'b1;
      ST_IDLE:  ctl.load      = start;
      ST_EXEC:  ctl.exec      = 1'b1;
      ST_READ:  ctl.take_read = 1'b1;
      ST_COPY:  ctl.copy_step = 1'b1;
      ST_DRAIN: ctl           = '0;
      ST_FILL:  ctl.fill_step = 1'b1;
      default:  ctl           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_report <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (stat.last_cell) begin
            state <= ST_IDLE;
            done  <= clr_report;
          end
        end
        ST_IDLE: begin
          if (start) state <= ST_EXEC;
        end
        ST_EXEC: begin
          priority case (stat.mode)
            MODE_PUT: begin
              if (stat.need_scroll) begin
                state <= ST_COPY;
              end else begin
                state <= ST_IDLE;
                done  <= 1'b1;
              end
            end
            MODE_CLEAR: begin
              clr_report <= 1'b1;
              state      <= ST_CLEAR;
            end
            MODE_READ: state <= ST_READ;
            default: begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          endcase
        end
        ST_READ: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_COPY: begin
          if (stat.copy_last) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_FILL;
        ST_FILL: begin
          if (stat.last_cell) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TCCW_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  `TCCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not start")
  `TCCW_ASSERT_NEXT(a_done_single, done, !done, "result strobe lasted two cycles")

endmodule

// ===== rtl/core/text_console_char_writer.sv =====
// Text console, COLUMNS x ROWS cells of 16 bits (attribute over character).
// Command channel: mode, char_code and cell_index are transferred at a rising
// edge with start high and busy low. Mode 0 puts one byte, mode 1 clears the
// screen, mode 2 reads one cell, mode 3 only returns a result.
// Result channel: done is high for one cycle with cursor_position and
// cell_value; the receiver has no way to stall it and must take it then.
// States per command (from accept to the next possible accept):
//   put without scroll: EXEC; read: EXEC, then READ (registered RAM read).
//   put that scrolls: EXEC, COPY, DRAIN, FILL; the single RAM port pair
//   moves one cell per cycle (copy up, then blank the bottom row).
//   clear: EXEC, then CLEAR, one cell blanked per cycle.
// Reset: the cursor homes and a blanking pass runs over the screen RAM
// with busy high; it gives no result.
module text_console_char_writer #(
  parameter int COLUMNS = tccw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tccw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_value
);
  import tccw_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  tccw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl),
    .stat  (stat)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .mode            (mode),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .cursor_position (cursor_position),
    .cell_value      (cell_value)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import tccw_pkg::*;

  localparam int COLS  = DEF_COLUMNS;
  localparam int LINES = DEF_ROWS;
  localparam int CELLS = COLS * LINES;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] CH_LAST_PRINT = 8'h7F;
  localparam int RANDOM_CMDS = 1350;
  // longest command is a clear or a scroll
  localparam int SETTLE_CYCLES = CELLS + 200;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [10:0] idx;
    logic        drain;  // hold this transfer until all results are back
  } console_cmd_t;

  typedef struct packed {
    logic [10:0] cursor;
    logic [15:0] cell_val;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = '0;
  logic [7:0]  char_code = '0;
  logic [10:0] cell_index = '0;
  logic        busy;
  logic        done;
  logic [10:0] cursor_position;
  logic [15:0] cell_value;

  console_cmd_t    cmd_q[$];
  console_result_t awaited[$];
  logic [15:0]     screen[CELLS];
  int              cur_col;
  int              cur_row;
  int              sent_count = 0;
  int              taken_count = 0;
  int              total_cmds = 0;
  int              mismatches = 0;
  int              idle_pct;
  console_cmd_t    next_cmd;
  console_result_t got;
  console_result_t want;

  text_console_char_writer uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .char_code(char_code),
    .cell_index(cell_index),
    .done(done),
    .cursor_position(cursor_position),
    .cell_value(cell_value)
  );

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic void put_char(logic [7:0] c);
    if (c == CH_BS) begin
      if (cur_col != 0) cur_col--;
    end else if (c == CH_TAB) begin
      cur_col = (cur_col + 8) & ~7;
    end else if (c == CH_CR) begin
      cur_col = 0;
    end else if (c == CH_LF) begin
      cur_col = 0;
      cur_row++;
    end else if (c >= CH_SPACE && c <= CH_LAST_PRINT) begin
      screen[cur_row * COLS + cur_col] = {ATTR_WHITE, c};
      cur_col++;
    end
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= LINES) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = BLANK_CELL;
      cur_row = LINES - 1;
    end
  endfunction

  function automatic console_result_t console_step(logic [1:0] op, logic [7:0] ch,
                                                   logic [10:0] idx);
    console_result_t r;
    r.cell_val = '0;
    case (op)
      MODE_PUT: put_char(ch);
      MODE_CLEAR: blank_screen();
      MODE_READ: begin
        if (idx < CELLS) r.cell_val = screen[idx];
      end
      default: ;
    endcase
    r.cursor = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic void push_cmd(logic [1:0] op, logic [7:0] ch, logic [10:0] idx,
                                   logic drain = 1'b0);
    console_cmd_t c;
    c.op = op;
    c.ch = ch;
    c.idx = idx;
    c.drain = drain;
    cmd_q.push_back(c);
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    blank_screen();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // driver: one command per transfer, held until the block takes it
  always @(negedge clk) begin
    if (!rst && sent_count == taken_count) begin
      if (sent_count < total_cmds / 3) idle_pct = 6;
      else if (sent_count < 2 * total_cmds / 3) idle_pct = 47;
      else idle_pct = 0;
      if (cmd_q.size() != 0 && !(cmd_q[0].drain && awaited.size() != 0) &&
          $urandom_range(99, 0) >= idle_pct) begin
        next_cmd = cmd_q.pop_front();
        start <= 1'b1;
        mode <= next_cmd.op;
        char_code <= next_cmd.ch;
        cell_index <= next_cmd.idx;
        sent_count++;
      end else begin
        start <= 1'b0;
        mode <= 2'($urandom);
        char_code <= 8'($urandom);
        cell_index <= 11'($urandom);
      end
    end
  end

  // monitor: check results in order, predict on each accepted transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got.cursor = cursor_position;
        got.cell_val = cell_value;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: cursor_position %0d cell_value %h",
                     got.cursor, got.cell_val);
        end else begin
          want = awaited.pop_front();
          if (got.cursor !== want.cursor || got.cell_val !== want.cell_val) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: cursor_position %0d (exp %0d) cell_value %h (exp %h)",
                       got.cursor, want.cursor, got.cell_val, want.cell_val);
          end
        end
      end
      if (start && !busy) begin
        awaited.push_back(console_step(mode, char_code, cell_index));
        taken_count++;
      end
    end
  end

  initial begin
    int r;
    int n;
    logic [7:0] c;
    logic [10:0] idx;

    // directed
    push_cmd(MODE_READ, 8'h00, 11'd0);
    push_cmd(MODE_PUT, 8'h41, 11'h7FF);
    push_cmd(MODE_READ, 8'hFF, 11'd0);
    push_cmd(MODE_PUT, CH_BS, 11'd0);
    push_cmd(MODE_PUT, CH_BS, 11'd0);          // backspace at column 0
    push_cmd(MODE_PUT, CH_TAB, 11'd0);
    push_cmd(MODE_PUT, CH_TAB, 11'd0);
    push_cmd(MODE_PUT, CH_LAST_PRINT, 11'd0);
    push_cmd(MODE_PUT, CH_SPACE, 11'd0);
    push_cmd(MODE_PUT, 8'h1F, 11'd0);
    push_cmd(MODE_PUT, 8'h80, 11'd0);          // high bytes are ignored
    push_cmd(MODE_PUT, 8'hFF, 11'd0);
    push_cmd(MODE_PUT, 8'h00, 11'd0);
    push_cmd(MODE_PUT, CH_CR, 11'd0);
    push_cmd(MODE_PUT, CH_LF, 11'd0);
    push_cmd(MODE_UNUSED, 8'h41, 11'd5);
    push_cmd(MODE_READ, 8'h00, 11'h7FF);       // past the last cell
    push_cmd(MODE_READ, 8'h00, 11'(CELLS));
    push_cmd(MODE_READ, 8'h00, 11'(CELLS - 1));
    push_cmd(MODE_READ, 8'h00, 11'd16);
    push_cmd(MODE_CLEAR, 8'h00, 11'd0);
    push_cmd(MODE_READ, 8'h00, 11'd16);

    n = cmd_q.size();
    while (cmd_q.size() < n + RANDOM_CMDS) begin
      r = $urandom_range(999, 0);
      if (r < 6) begin
        // long run of text so the column wraps
        repeat ($urandom_range(120, 60))
          push_cmd(MODE_PUT, 8'($urandom_range(CH_LAST_PRINT, CH_SPACE)), 11'($urandom));
      end else if (r < 20) begin
        // mostly line feeds, drives the cursor to the bottom and scrolls
        repeat ($urandom_range(25, 5)) begin
          if ($urandom_range(3, 0) == 0) c = 8'($urandom_range(CH_LAST_PRINT, CH_SPACE));
          else c = CH_LF;
          push_cmd(MODE_PUT, c, 11'($urandom));
        end
      end else if (r < 25) begin
        push_cmd(MODE_CLEAR, 8'($urandom), 11'($urandom));
      end else if (r < 40) begin
        push_cmd(MODE_UNUSED, 8'($urandom), 11'($urandom));
      end else if (r < 240) begin
        r = $urandom_range(99, 0);
        if (r < 5) idx = 11'($urandom_range(2047, CELLS));
        else if (r < 25) idx = 11'($urandom_range(CELLS - 1, CELLS - COLS));
        else if (r < 35) idx = 11'($urandom_range(COLS - 1, 0));
        else idx = 11'($urandom_range(CELLS - 1, 0));
        push_cmd(MODE_READ, 8'($urandom), idx, $urandom_range(19, 0) == 0);
      end else if (r < 280) begin
        do c = 8'($urandom);
        while ((c >= CH_SPACE && c <= CH_LAST_PRINT) || c == CH_BS || c == CH_TAB ||
               c == CH_LF || c == CH_CR);
        push_cmd(MODE_PUT, c, 11'($urandom));
      end else if (r < 320) begin
        push_cmd(MODE_PUT, CH_BS, 11'($urandom));
      end else if (r < 360) begin
        push_cmd(MODE_PUT, CH_TAB, 11'($urandom));
      end else if (r < 390) begin
        push_cmd(MODE_PUT, CH_CR, 11'($urandom));
      end else if (r < 470) begin
        push_cmd(MODE_PUT, CH_LF, 11'($urandom));
      end else begin
        push_cmd(MODE_PUT, 8'($urandom_range(CH_LAST_PRINT, CH_SPACE)), 11'($urandom));
      end
    end
    cmd_q[n].drain = 1'b1;
    total_cmds = cmd_q.size();
    cmd_q[total_cmds / 3].drain = 1'b1;
    cmd_q[2 * total_cmds / 3].drain = 1'b1;

    while (cmd_q.size() != 0 || sent_count != taken_count || awaited.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
